FILE: hdl/humidity_temp_frame_decoder_assert.svh
// assertion macros shared by the decoder modules
`ifndef HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH

// property checked on every clock edge outside reset
`define HTFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// types, constants and the crc-8 step for the sensor frame decoder
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumScale   = 14'd10000;
  localparam logic [14:0] TempOffset = 15'd4500;
  localparam logic [16:0] RawFull    = 17'd65535;

  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } htfd_pos_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } htfd_in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [15:0]        temperature_raw;
    logic [15:0]        humidity_raw;
    logic               temperature_crc_ok;
    logic               humidity_crc_ok;
    logic               frame_valid;
  } htfd_out_t;

  // one complete frame handed from the front to the back
  typedef struct packed {
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic        temp_ok;
    logic        hum_ok;
  } htfd_frame_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/humidity_temp_frame_decoder.sv
// path: out_valid_o rises once the frame completed by the sixth byte has passed the
//   queue, the scale multiply stage and the output register, in that order
// throughput: one byte per cycle while the queue is not full, one result per six bytes
// reset: asynchronous active low; frame position to the first byte, crc to 0xff,
//   queue and pipeline empty
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// decodes the six-byte humidity and temperature reply into checked values
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder import htfd_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  htfd_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output htfd_out_t out_data_o
);

  logic        push_valid, push_ready;
  htfd_frame_t push_data;
  logic        pop_valid, pop_ready;
  htfd_frame_t pop_data;

  htfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  htfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  htfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (pop_valid),
    .frm_ready_o (pop_ready),
    .frm_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/htfd_front.sv
// ----------------------------------------------------------------------------
// htfd_front
// byte sequencer: tracks frame position, runs the crc, assembles the words
// ----------------------------------------------------------------------------
module htfd_front import htfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  htfd_in_t    in_data_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output htfd_frame_t push_data_o
);

  htfd_pos_e   pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] tword_q, tword_d;
  logic [15:0] hword_q, hword_d;
  logic        tflag_q, tflag_d;
  logic        accept;
  logic        last_byte;
  logic [7:0]  b;

  assign b          = in_data_i.rx_byte;
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (in_data_i.frame_start || (pos_q > POS_H_CRC)) begin
      pos_eff = POS_T_HI;
    end else begin
      pos_eff = pos_q;
    end
  end

  assign last_byte = (pos_eff == POS_H_CRC);

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    hi_d    = hi_q;
    tword_d = tword_q;
    hword_d = hword_q;
    tflag_d = tflag_q;
    if (accept) begin
      case (pos_eff)
        POS_T_HI: begin
          crc_d = crc8_update(CrcInit, b);
          hi_d  = b;
          pos_d = POS_T_LO;
        end
        POS_T_LO: begin
          crc_d   = crc8_update(crc_q, b);
          tword_d = {hi_q, b};
          pos_d   = POS_T_CRC;
        end
        POS_T_CRC: begin
          tflag_d = (crc_q == b);
          crc_d   = CrcInit;
          pos_d   = POS_H_HI;
        end
        POS_H_HI: begin
          crc_d = crc8_update(CrcInit, b);
          hi_d  = b;
          pos_d = POS_H_LO;
        end
        POS_H_LO: begin
          crc_d   = crc8_update(crc_q, b);
          hword_d = {hi_q, b};
          pos_d   = POS_H_CRC;
        end
        default: begin
          crc_d = CrcInit;
          pos_d = POS_T_HI;
        end
      endcase
    end
  end

  assign push_valid_o         = accept && last_byte;
  assign push_data_o.temp_raw = tword_q;
  assign push_data_o.hum_raw  = hword_q;
  assign push_data_o.temp_ok  = tflag_q;
  assign push_data_o.hum_ok   = (crc_q == b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_T_HI;
      crc_q   <= CrcInit;
      hi_q    <= '0;
      tword_q <= '0;
      hword_q <= '0;
      tflag_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      hi_q    <= hi_d;
      tword_q <= tword_d;
      hword_q <= hword_d;
      tflag_q <= tflag_d;
    end
  end

endmodule

FILE: hdl/htfd_fifo.sv
// ----------------------------------------------------------------------------
// htfd_fifo
// short frame queue between the byte sequencer and the conversion pipeline
// ----------------------------------------------------------------------------
module htfd_fifo import htfd_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  htfd_frame_t push_data_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output htfd_frame_t pop_data_o
);

  `include "humidity_temp_frame_decoder_assert.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  htfd_frame_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `HTFD_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count above depth")
  `HTFD_ASSERT_NEXT(a_count_inc, push && !pop, count_q == $past(count_q) + 1'b1, "queue count missed a push")
  `HTFD_ASSERT_NEXT(a_count_dec, pop && !push, count_q == $past(count_q) - 1'b1, "queue count missed a pop")

endmodule

FILE: hdl/htfd_back.sv
// ----------------------------------------------------------------------------
// htfd_back
// conversion pipeline: scale multiply, divide by full scale, temperature offset, output register
// ----------------------------------------------------------------------------
module htfd_back import htfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        frm_valid_i,
  output logic        frm_ready_o,
  input  htfd_frame_t frm_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output htfd_out_t   out_data_o
);

  `include "humidity_temp_frame_decoder_assert.svh"

  logic        a_valid_q;
  logic [30:0] tprod_q;
  logic [29:0] hprod_q;
  htfd_frame_t a_frm_q;
  logic        out_valid_q;
  htfd_out_t   out_q;
  logic        a_ready, b_ready;
  logic        a_load, b_load;

  logic [14:0] tq_est, tq;
  logic [13:0] hq_est, hq;
  logic [16:0] trem, hrem;
  htfd_out_t   res;

  assign b_ready     = !out_valid_q || out_ready_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign frm_ready_o = a_ready;
  assign a_load      = frm_valid_i && a_ready;
  assign b_load      = a_valid_q && b_ready;

  // x / 65535: estimate x >> 16, remainder estimate is low half plus estimate
  assign tq_est = tprod_q[30:16];
  assign trem   = {1'b0, tprod_q[15:0]} + {2'b0, tq_est};
  assign tq     = tq_est + 15'((trem >= RawFull) ? 1 : 0);
  assign hq_est = hprod_q[29:16];
  assign hrem   = {1'b0, hprod_q[15:0]} + {3'b0, hq_est};
  assign hq     = hq_est + 14'((hrem >= RawFull) ? 1 : 0);

  always_comb begin
    res.temperature_centi  = signed'(tq - TempOffset);
    res.humidity_centi     = hq;
    res.temperature_raw    = a_frm_q.temp_raw;
    res.humidity_raw       = a_frm_q.hum_raw;
    res.temperature_crc_ok = a_frm_q.temp_ok;
    res.humidity_crc_ok    = a_frm_q.hum_ok;
    res.frame_valid        = a_frm_q.temp_ok && a_frm_q.hum_ok;
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      tprod_q <= 31'({16'b0, TempScale} * {15'b0, frm_data_i.temp_raw});
      hprod_q <= 30'({16'b0, HumScale} * {14'b0, frm_data_i.hum_raw});
      a_frm_q <= frm_data_i;
    end
    if (b_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= frm_valid_i;
      end
      if (b_ready) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HTFD_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i, out_valid_q && $stable(out_q), "result changed while stalled")
  `HTFD_ASSERT_NEXT(a_stage_fwd, a_valid_q && b_ready, out_valid_q, "converted frame lost")
  `HTFD_ASSERT(a_hum_range, !out_valid_q || (out_q.humidity_centi <= HumScale), "humidity above full scale")

endmodule
